FILE: src/sorted_timeout_timer_pool_top_assert.svh
// Assertion macros for the timer pool checker
`ifndef SORTED_TIMEOUT_TIMER_POOL_TOP_ASSERT_SVH
`define SORTED_TIMEOUT_TIMER_POOL_TOP_ASSERT_SVH

// same-cycle implication, disabled while rst_n is low
`define STP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while rst_n is low
`define STP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/stp_pkg.sv
// Types and constants of the sorted timeout timer pool
`default_nettype none
package stp_pkg;

  localparam int POOL_SIZE_DEF = 16;
  localparam int TAG_WIDTH_DEF = 16;
  localparam int MAX_RESULTS   = 16;
  localparam int CNT_W         = $clog2(MAX_RESULTS + 1);
  localparam int SLOT_W        = 4;
  localparam int OUT_TAG_W     = 16;
  localparam logic [31:0] NEVER = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_ALLOC = 3'd1,
    OP_FREE  = 3'd2,
    OP_CB    = 3'd3,
    OP_ARM   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_WRONG  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SS_FREE  = 2'd0,
    SS_ALLOC = 2'd1,
    SS_PEND  = 2'd2
  } sstate_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_RESP, S_SCAN, S_TCHK, S_TPOP, S_THDL, S_TEMIT,
    S_ALINK, S_AWALK, S_ACMP, S_AINS
  } fsm_t;

endpackage
`default_nettype wire

FILE: src/stp_ifs.sv
// Request and result channel interfaces of the timer pool
`default_nettype none
interface stp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [3:0]  slot;
  logic [31:0] delay;
  logic [15:0] callback_tag;
  modport source (output valid, operation, slot, delay, callback_tag, input ready);
  modport sink (input valid, operation, slot, delay, callback_tag, output ready);
endinterface

interface stp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  result_slot;
  logic        expired;
  logic [15:0] expired_tag;
  logic        last;
  modport source (output valid, status, result_slot, expired, expired_tag, last,
                  input ready);
  modport sink (input valid, status, result_slot, expired, expired_tag, last,
                output ready);
endinterface
`default_nettype wire

FILE: src/sorted_timeout_timer_pool_top.sv
// Tick: pops and reports each due timer in deadline order, up to 16 per tick, else one plain
// result when nothing is due.
// Allocate: scans slots 0 to min(POOL_SIZE, 16) - 1, one slot scanned per cycle.
// Arm: inserts at the head, else walks the list comparing entries, appending at the tail when latest.
// Free, set callback, unknown codes: answered directly. One transaction in flight at a time.
// Reset: synchronous, active low; all slots free, list empty, counter zero.
`default_nettype none
module sorted_timeout_timer_pool_top #(
  parameter int POOL_SIZE = stp_pkg::POOL_SIZE_DEF,
  parameter int TAG_WIDTH = stp_pkg::TAG_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  stp_in_if.sink     in_ch,
  stp_out_if.source  out_ch
);

  localparam int SW = $clog2(POOL_SIZE);
  localparam int LW = $clog2(POOL_SIZE + 1);
  localparam int ALLOC_N = (POOL_SIZE < 16) ? POOL_SIZE : 16;
  localparam logic [SW-1:0] ALLOC_LAST = SW'(ALLOC_N - 1);

  stp_pkg::fsm_t    fsm_r, fsm_nxt;
  stp_pkg::op_t     op_r, op_nxt;
  logic [3:0]       slot_r, slot_nxt;
  logic [31:0]      delay_r, delay_nxt;
  logic [15:0]      tagin_r, tagin_nxt;
  logic [31:0]      tick_r, tick_nxt;
  logic [31:0]      earliest_r, earliest_nxt;
  logic [SW-1:0]    head_r, head_nxt;
  logic             empty_r, empty_nxt;
  logic [LW-1:0]    len_r, len_nxt;
  logic [31:0]      d_r, d_nxt;
  logic [SW-1:0]    prev_r, prev_nxt;
  logic [SW-1:0]    cur_r, cur_nxt;
  logic [LW-1:0]    i_r, i_nxt;
  logic [stp_pkg::CNT_W-1:0] n_r, n_nxt;
  logic [SW-1:0]    scan_r, scan_nxt;
  logic [SW-1:0]    ps_r, ps_nxt;
  logic [TAG_WIDTH-1:0] ptag_r, ptag_nxt;
  stp_pkg::status_t res_status_r, res_status_nxt;
  logic [3:0]       res_slot_r, res_slot_nxt;
  stp_pkg::sstate_t ss_r [POOL_SIZE];

  logic             out_valid_r;
  stp_pkg::status_t out_status_r;
  logic [3:0]       out_slot_r;
  logic             out_exp_r;
  logic [15:0]      out_tag_r;
  logic             out_last_r;

  logic [31:0]          dl_mem [POOL_SIZE];
  logic [SW-1:0]        nx_mem [POOL_SIZE];
  logic [TAG_WIDTH-1:0] tg_mem [POOL_SIZE];
  logic [31:0]          dl_q;
  logic [SW-1:0]        nx_q;
  logic [TAG_WIDTH-1:0] tg_q;

  logic [SW-1:0]    rd_addr;
  logic             dl_we, nx_we, tg_we, ss_we;
  logic [SW-1:0]    nx_wa, ss_wa;
  logic [SW-1:0]    nx_wd;
  stp_pkg::sstate_t ss_wd;

  logic             emit, ofree, more;
  stp_pkg::status_t e_status;
  logic [3:0]       e_slot;
  logic             e_exp, e_last;
  logic [15:0]      e_tag;

  logic [SW-1:0]    sidx;
  logic             slot_ok;
  logic [32:0]      arm_sum;

  assign sidx    = SW'(slot_r);
  assign slot_ok = {3'b000, slot_r} < 7'(POOL_SIZE);
  assign arm_sum = {1'b0, tick_r} + {1'b0, delay_r};
  assign ofree   = !out_valid_r || out_ch.ready;
  assign more    = !empty_r && (n_r < stp_pkg::CNT_W'(stp_pkg::MAX_RESULTS)) &&
                   (earliest_r <= tick_r);

  always_comb begin
    fsm_nxt = fsm_r;
    op_nxt = op_r;
    slot_nxt = slot_r;
    delay_nxt = delay_r;
    tagin_nxt = tagin_r;
    tick_nxt = tick_r;
    earliest_nxt = earliest_r;
    head_nxt = head_r;
    empty_nxt = empty_r;
    len_nxt = len_r;
    d_nxt = d_r;
    prev_nxt = prev_r;
    cur_nxt = cur_r;
    i_nxt = i_r;
    n_nxt = n_r;
    scan_nxt = scan_r;
    ps_nxt = ps_r;
    ptag_nxt = ptag_r;
    res_status_nxt = res_status_r;
    res_slot_nxt = res_slot_r;
    rd_addr = head_r;
    dl_we = 1'b0;
    nx_we = 1'b0;
    nx_wa = sidx;
    nx_wd = head_r;
    tg_we = 1'b0;
    ss_we = 1'b0;
    ss_wa = sidx;
    ss_wd = stp_pkg::SS_ALLOC;
    emit = 1'b0;
    e_status = stp_pkg::ST_OK;
    e_slot = 4'd0;
    e_exp = 1'b0;
    e_tag = 16'd0;
    e_last = 1'b1;
    in_ch.ready = 1'b0;
    case (fsm_r)
      stp_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          op_nxt = stp_pkg::op_t'(in_ch.operation);
          slot_nxt = in_ch.slot;
          delay_nxt = in_ch.delay;
          tagin_nxt = in_ch.callback_tag;
          fsm_nxt = stp_pkg::S_EXEC;
        end
      end
      stp_pkg::S_EXEC: begin
        res_status_nxt = stp_pkg::ST_OK;
        res_slot_nxt = 4'd0;
        fsm_nxt = stp_pkg::S_RESP;
        case (op_r)
          stp_pkg::OP_TICK: begin
            if (tick_r != stp_pkg::NEVER) tick_nxt = tick_r + 32'd1;
            n_nxt = '0;
            fsm_nxt = stp_pkg::S_TCHK;
          end
          stp_pkg::OP_ALLOC: begin
            scan_nxt = '0;
            fsm_nxt = stp_pkg::S_SCAN;
          end
          stp_pkg::OP_FREE: begin
            if (!slot_ok || ss_r[sidx] == stp_pkg::SS_PEND) begin
              res_status_nxt = stp_pkg::ST_WRONG;
            end else begin
              ss_we = 1'b1;
              ss_wd = stp_pkg::SS_FREE;
            end
          end
          stp_pkg::OP_CB: begin
            if (!slot_ok) res_status_nxt = stp_pkg::ST_WRONG;
            else tg_we = 1'b1;
          end
          stp_pkg::OP_ARM: begin
            if (!slot_ok || ss_r[sidx] != stp_pkg::SS_ALLOC) begin
              res_status_nxt = stp_pkg::ST_WRONG;
            end else begin
              d_nxt = arm_sum[32] ? stp_pkg::NEVER : arm_sum[31:0];
              fsm_nxt = stp_pkg::S_ALINK;
            end
          end
          default: ;
        endcase
      end
      stp_pkg::S_RESP: begin
        emit = 1'b1;
        e_status = res_status_r;
        e_slot = res_slot_r;
        if (ofree) fsm_nxt = stp_pkg::S_IDLE;
      end
      stp_pkg::S_SCAN: begin
        if (ss_r[scan_r] == stp_pkg::SS_FREE) begin
          ss_we = 1'b1;
          ss_wa = scan_r;
          res_status_nxt = stp_pkg::ST_OK;
          res_slot_nxt = 4'(scan_r);
          fsm_nxt = stp_pkg::S_RESP;
        end else if (scan_r == ALLOC_LAST) begin
          res_status_nxt = stp_pkg::ST_NOFREE;
          res_slot_nxt = 4'd0;
          fsm_nxt = stp_pkg::S_RESP;
        end else begin
          scan_nxt = scan_r + SW'(1);
        end
      end
      stp_pkg::S_TCHK: begin
        if (!empty_r && earliest_r <= tick_r) fsm_nxt = stp_pkg::S_TPOP;
        else fsm_nxt = stp_pkg::S_RESP;
      end
      stp_pkg::S_TPOP: begin
        ss_we = 1'b1;
        ss_wa = head_r;
        ps_nxt = head_r;
        ptag_nxt = tg_q;
        n_nxt = n_r + stp_pkg::CNT_W'(1);
        len_nxt = len_r - LW'(1);
        if (len_r == LW'(1)) begin
          empty_nxt = 1'b1;
          head_nxt = '0;
          earliest_nxt = stp_pkg::NEVER;
          fsm_nxt = stp_pkg::S_TEMIT;
        end else begin
          head_nxt = nx_q;
          rd_addr = nx_q;
          fsm_nxt = stp_pkg::S_THDL;
        end
      end
      stp_pkg::S_THDL: begin
        earliest_nxt = dl_q;
        fsm_nxt = stp_pkg::S_TEMIT;
      end
      stp_pkg::S_TEMIT: begin
        emit = 1'b1;
        e_slot = 4'(ps_r);
        e_exp = 1'b1;
        e_tag = 16'(ptag_r);
        e_last = !more;
        if (ofree) fsm_nxt = more ? stp_pkg::S_TPOP : stp_pkg::S_IDLE;
      end
      stp_pkg::S_ALINK: begin
        ss_we = 1'b1;
        ss_wd = stp_pkg::SS_PEND;
        dl_we = 1'b1;
        if (empty_r) begin
          head_nxt = sidx;
          len_nxt = LW'(1);
          empty_nxt = 1'b0;
          earliest_nxt = d_r;
          fsm_nxt = stp_pkg::S_RESP;
        end else if (d_r <= earliest_r) begin
          nx_we = 1'b1;
          head_nxt = sidx;
          len_nxt = len_r + LW'(1);
          earliest_nxt = d_r;
          fsm_nxt = stp_pkg::S_RESP;
        end else begin
          prev_nxt = head_r;
          i_nxt = LW'(1);
          fsm_nxt = stp_pkg::S_AWALK;
        end
      end
      stp_pkg::S_AWALK: begin
        if (i_r < len_r) begin
          cur_nxt = nx_q;
          rd_addr = nx_q;
          fsm_nxt = stp_pkg::S_ACMP;
        end else begin
          nx_we = 1'b1;
          nx_wd = nx_q;
          fsm_nxt = stp_pkg::S_AINS;
        end
      end
      stp_pkg::S_ACMP: begin
        if (d_r <= dl_q) begin
          nx_we = 1'b1;
          nx_wd = cur_r;
          fsm_nxt = stp_pkg::S_AINS;
        end else begin
          prev_nxt = cur_r;
          i_nxt = i_r + LW'(1);
          rd_addr = cur_r;
          fsm_nxt = stp_pkg::S_AWALK;
        end
      end
      stp_pkg::S_AINS: begin
        nx_we = 1'b1;
        nx_wa = prev_r;
        nx_wd = sidx;
        len_nxt = len_r + LW'(1);
        fsm_nxt = stp_pkg::S_RESP;
      end
      default: fsm_nxt = stp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r <= stp_pkg::S_IDLE;
      tick_r <= '0;
      earliest_r <= stp_pkg::NEVER;
      head_r <= '0;
      empty_r <= 1'b1;
      len_r <= '0;
      for (int k = 0; k < POOL_SIZE; k++) ss_r[k] <= stp_pkg::SS_FREE;
    end else begin
      fsm_r <= fsm_nxt;
      tick_r <= tick_nxt;
      earliest_r <= earliest_nxt;
      head_r <= head_nxt;
      empty_r <= empty_nxt;
      len_r <= len_nxt;
      if (ss_we) ss_r[ss_wa] <= ss_wd;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    slot_r <= slot_nxt;
    delay_r <= delay_nxt;
    tagin_r <= tagin_nxt;
    d_r <= d_nxt;
    prev_r <= prev_nxt;
    cur_r <= cur_nxt;
    i_r <= i_nxt;
    n_r <= n_nxt;
    scan_r <= scan_nxt;
    ps_r <= ps_nxt;
    ptag_r <= ptag_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r <= res_slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (dl_we) dl_mem[sidx] <= d_r;
    dl_q <= dl_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    nx_q <= nx_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (tg_we) tg_mem[sidx] <= TAG_WIDTH'(tagin_r);
    tg_q <= tg_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit && ofree) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && ofree) begin
      out_status_r <= e_status;
      out_slot_r <= e_slot;
      out_exp_r <= e_exp;
      out_tag_r <= e_tag;
      out_last_r <= e_last;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.result_slot = out_slot_r;
  assign out_ch.expired = out_exp_r;
  assign out_ch.expired_tag = out_tag_r;
  assign out_ch.last = out_last_r;

endmodule
`default_nettype wire

FILE: src/stp_chk.sv
// Port-level checker for the timer pool and its bind
`default_nettype none
`include "sorted_timeout_timer_pool_top_assert.svh"
module stp_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status,
  input wire logic       out_expired,
  input wire logic       out_last
);

  `STP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `STP_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second transaction taken early")
  `STP_ASSERT_IMP(a_single_last, out_valid && !out_expired, out_last, "plain result not last")
  `STP_ASSERT_IMP(a_exp_ok, out_valid && out_expired, out_status == stp_pkg::ST_OK, "expiry with bad status")

endmodule

bind sorted_timeout_timer_pool_top stp_chk u_stp_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_status  (out_ch.status),
  .out_expired (out_ch.expired),
  .out_last    (out_ch.last)
);
`default_nettype wire

FILE: bench/sorted_timeout_timer_pool_top_tb.sv
// Self-checking testbench of the sorted timeout timer pool, with a built-in predictor
`timescale 1ns / 1ps
`default_nettype none
module sorted_timeout_timer_pool_top_tb;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic        expired;
    logic [15:0] tag;
    logic        last;
  } outcome_t;

  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  stp_in_if  in_if();
  stp_out_if out_if();

  sorted_timeout_timer_pool_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  outcome_t         outcome_q[$];
  logic [3:0]       armed_q[$];
  stp_pkg::sstate_t slot_st[16];
  logic [31:0]      slot_due[16];
  logic [15:0]      slot_cb[16];
  bit               cb_known[16];
  logic [31:0]      ticks;
  int               mismatches = 0;
  int               cycles = 0;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;

  function automatic void add_outcome(stp_pkg::status_t st, logic [3:0] s, logic ex,
                                      logic [15:0] tg, logic lst);
    outcome_t r;
    r.status = st;
    r.slot = s;
    r.expired = ex;
    r.tag = tg;
    r.last = lst;
    outcome_q.push_back(r);
  endfunction

  function automatic void predict_pool(logic [2:0] opc, logic [3:0] s, logic [31:0] dly,
                                       logic [15:0] tg);
    int n;
    int pos;
    logic [3:0] h;
    logic [32:0] sum;
    logic [31:0] due;
    outcome_t r;
    bit found;
    n = 0;
    found = 0;
    case (opc)
      stp_pkg::OP_TICK: begin
        if (ticks != stp_pkg::NEVER) ticks = ticks + 1;
        while (armed_q.size() > 0 && n < stp_pkg::MAX_RESULTS &&
               slot_due[armed_q[0]] <= ticks) begin
          h = armed_q.pop_front();
          slot_st[h] = stp_pkg::SS_ALLOC;
          add_outcome(stp_pkg::ST_OK, h, 1'b1, slot_cb[h], 1'b0);
          n++;
        end
        if (n == 0) begin
          add_outcome(stp_pkg::ST_OK, 4'd0, 1'b0, 16'd0, 1'b1);
        end else begin
          r = outcome_q.pop_back();
          r.last = 1'b1;
          outcome_q.push_back(r);
        end
      end
      stp_pkg::OP_ALLOC: begin
        for (int i = 0; i < 16; i++) begin
          if (!found && slot_st[i] == stp_pkg::SS_FREE) begin
            slot_st[i] = stp_pkg::SS_ALLOC;
            add_outcome(stp_pkg::ST_OK, 4'(i), 1'b0, 16'd0, 1'b1);
            found = 1;
          end
        end
        if (!found) add_outcome(stp_pkg::ST_NOFREE, 4'd0, 1'b0, 16'd0, 1'b1);
      end
      stp_pkg::OP_FREE: begin
        if (slot_st[s] == stp_pkg::SS_PEND) begin
          add_outcome(stp_pkg::ST_WRONG, 4'd0, 1'b0, 16'd0, 1'b1);
        end else begin
          slot_st[s] = stp_pkg::SS_FREE;
          add_outcome(stp_pkg::ST_OK, 4'd0, 1'b0, 16'd0, 1'b1);
        end
      end
      stp_pkg::OP_CB: begin
        slot_cb[s] = tg;
        add_outcome(stp_pkg::ST_OK, 4'd0, 1'b0, 16'd0, 1'b1);
      end
      stp_pkg::OP_ARM: begin
        if (slot_st[s] != stp_pkg::SS_ALLOC) begin
          add_outcome(stp_pkg::ST_WRONG, 4'd0, 1'b0, 16'd0, 1'b1);
        end else begin
          sum = {1'b0, ticks} + {1'b0, dly};
          due = sum[32] ? stp_pkg::NEVER : sum[31:0];
          slot_due[s] = due;
          slot_st[s] = stp_pkg::SS_PEND;
          pos = armed_q.size();
          for (int i = armed_q.size() - 1; i >= 0; i--) begin
            if (due <= slot_due[armed_q[i]]) pos = i;
          end
          armed_q.insert(pos, s);
          add_outcome(stp_pkg::ST_OK, 4'd0, 1'b0, 16'd0, 1'b1);
        end
      end
      default: add_outcome(stp_pkg::ST_OK, 4'd0, 1'b0, 16'd0, 1'b1);
    endcase
  endfunction

  task automatic send_request(logic [2:0] opc, logic [3:0] s, logic [31:0] dly,
                              logic [15:0] tg);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.operation <= opc;
    in_if.slot <= s;
    in_if.delay <= dly;
    in_if.callback_tag <= tg;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (opc == stp_pkg::OP_CB) cb_known[s] = 1;
    predict_pool(opc, s, dly, tg);
  endtask

  task automatic drain_results();
    wait (outcome_q.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(stp_pkg::OP_TICK, 4'd0, 32'd0, 16'd0);
    repeat (3) send_request(stp_pkg::OP_ALLOC, 4'd0, 32'd0, 16'd0);
    send_request(stp_pkg::OP_CB, 4'd0, 32'd0, 16'h0000);
    send_request(stp_pkg::OP_CB, 4'd1, 32'd0, 16'hFFFF);
    send_request(stp_pkg::OP_CB, 4'd2, 32'd0, 16'hA5C3);
    send_request(stp_pkg::OP_ARM, 4'd0, 32'd2, 16'd0);
    send_request(stp_pkg::OP_ARM, 4'd1, 32'd2, 16'd0);
    send_request(stp_pkg::OP_ARM, 4'd2, 32'hFFFF_FFFF, 16'd0);
    send_request(stp_pkg::OP_ARM, 4'd0, 32'd1, 16'd0);
    send_request(stp_pkg::OP_FREE, 4'd1, 32'd0, 16'd0);
    send_request(stp_pkg::OP_FREE, 4'd15, 32'd0, 16'd0);
    send_request(stp_pkg::OP_CB, 4'd15, 32'd0, 16'hFFFF);
    send_request(stp_pkg::OP_ARM, 4'd15, 32'd3, 16'd0);
    send_request(3'd7, 4'd15, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(3'd5, 4'd0, 32'd0, 16'd0);
    send_request(3'd6, 4'd0, 32'd0, 16'd0);
    send_request(stp_pkg::OP_TICK, 4'd0, 32'd0, 16'd0);
    send_request(stp_pkg::OP_TICK, 4'd0, 32'd0, 16'd0);
    send_request(stp_pkg::OP_ARM, 4'd0, 32'd0, 16'd0);
    send_request(stp_pkg::OP_TICK, 4'd0, 32'd0, 16'd0);
  endtask

  task automatic test_exhaust();
    repeat (14) send_request(stp_pkg::OP_ALLOC, 4'd0, 32'd0, 16'd0);
    for (int i = 3; i < 16; i++) send_request(stp_pkg::OP_FREE, 4'(i), 32'd0, 16'd0);
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    int pick;
    logic [2:0] opc;
    logic [3:0] s;
    logic [31:0] dly;
    int owned[$];
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < count; k++) begin
      owned.delete();
      for (int i = 0; i < 16; i++) if (slot_st[i] == stp_pkg::SS_ALLOC) owned.push_back(i);
      s = 4'($urandom_range(15));
      if (owned.size() > 0 && $urandom_range(9) < 8) begin
        s = 4'(owned[$urandom_range(owned.size() - 1)]);
      end
      pick = $urandom_range(99);
      dly = 32'($urandom_range(6));
      if ($urandom_range(99) < 25) dly = 32'($urandom_range(40));
      if ($urandom_range(99) < 4) dly = $urandom;
      if (pick < 35) opc = stp_pkg::OP_TICK;
      else if (pick < 50) opc = stp_pkg::OP_ALLOC;
      else if (pick < 60) opc = stp_pkg::OP_FREE;
      else if (pick < 72) opc = stp_pkg::OP_CB;
      else if (pick < 97) opc = stp_pkg::OP_ARM;
      else opc = 3'($urandom_range(5, 7));
      if (opc == stp_pkg::OP_ARM && !cb_known[s]) opc = stp_pkg::OP_CB;
      send_request(opc, s, dly, 16'($urandom));
    end
  endtask

  task automatic test_quiet_pause();
    @(negedge clk);
    in_if.valid <= 1'b0;
    wait (outcome_q.size() == 0);
    send_request(stp_pkg::OP_TICK, 4'd0, 32'd0, 16'd0);
  endtask

  always @(negedge clk) begin
    if (rst_n) out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    cycles <= cycles + 1;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = {out_if.status, out_if.result_slot, out_if.expired, out_if.expired_tag, out_if.last};
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %p", got);
      end else begin
        want = outcome_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("sorted_timeout_timer_pool_top_tb: errors");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.operation = '0;
    in_if.slot = '0;
    in_if.delay = '0;
    in_if.callback_tag = '0;
    out_if.ready = 1'b0;
    ticks = '0;
    for (int i = 0; i < 16; i++) begin
      slot_st[i] = stp_pkg::SS_FREE;
      slot_due[i] = '0;
      slot_cb[i] = '0;
      cb_known[i] = 0;
    end
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_exhaust();
    test_random(45, 0, 0);
    test_quiet_pause();
    test_random(45, 85, 0);
    test_random(45, 0, 85);
    test_random(45, 12, 12);
    @(negedge clk);
    in_if.valid <= 1'b0;
    drain_results();
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("sorted_timeout_timer_pool_top_tb: clean");
    end else begin
      $display("sorted_timeout_timer_pool_top_tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
+incdir+src
src/stp_pkg.sv
src/stp_ifs.sv
src/sorted_timeout_timer_pool_top.sv
src/stp_chk.sv
bench/sorted_timeout_timer_pool_top_tb.sv
